/* src/idm_pkg.sv */
// Shared types and constants for the IoU detection matcher.
package idm_pkg;

  localparam int unsigned MAX_BOXES  = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_BOXES);
  localparam int unsigned CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned FRAC_SHIFT = 17;
  localparam int unsigned DIV_STEPS  = 16;
  localparam int unsigned SPAN_W     = 29;  // 16-bit Q0.16 times 13-bit pixels
  localparam int unsigned CRN_W      = 34;  // signed corner width, 2^-17 px units
  localparam int unsigned OVL_W      = 32;  // positive overlap width
  localparam int unsigned AREA_W     = 26;  // whole-pixel area
  localparam int unsigned UNI_W      = 61;  // union in 2^-34 px^2 units
  localparam int unsigned REM_W      = 62;  // divider remainder

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_SCORE = 2'd2,
    OP_CLOSE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_MATCH_THRESH = 2'd2
  } reg_e;

  typedef struct packed {
    op_e                   opcode;
    logic [15:0]           truth_center_x;
    logic [15:0]           truth_center_y;
    logic [15:0]           truth_box_w;
    logic [15:0]           truth_box_h;
    logic [COORD_BITS-1:0] pred_left;
    logic [COORD_BITS-1:0] pred_top;
    logic [12:0]           pred_w;
    logic [12:0]           pred_h;
  } in_word_t;

  typedef struct packed {
    logic           matched;
    logic [15:0]    best_iou;
    logic [31:0]    true_pos_count;
    logic [31:0]    false_pos_count;
    logic [31:0]    false_neg_count;
    logic [CNT_W-1:0] boxes_left;
    logic           table_full;
  } out_word_t;

  // prediction corners in 2^-17 pixel units, plus whole-pixel area
  typedef struct packed {
    logic signed [CRN_W-1:0] pl;
    logic signed [CRN_W-1:0] pr;
    logic signed [CRN_W-1:0] pt;
    logic signed [CRN_W-1:0] pb;
    logic [AREA_W-1:0]       area;
  } pred_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [15:0]      iou;
  } score_res_t;

endpackage

/* src/idm_score_pipe.sv */
// Pipelined IoU scorer: one table word in per cycle, one Q0.16 IoU out per cycle.
module idm_score_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [idm_pkg::IDX_W-1:0] idx_i,
  input  logic [63:0]               entry_i,
  input  idm_pkg::pred_t            pred_i,
  input  logic [12:0]               img_w_i,
  input  logic [12:0]               img_h_i,
  output idm_pkg::score_res_t       res_o
);
  import idm_pkg::*;

  // stage 1: spans
  logic              v1_q;
  logic [IDX_W-1:0]  idx1_q;
  logic [SPAN_W-1:0] ws1_q, hs1_q, cxw1_q, cyh1_q;
  // stage 2: overlaps and truth area
  logic              v2_q;
  logic [IDX_W-1:0]  idx2_q;
  logic [OVL_W-1:0]  dx2_q, dy2_q;
  logic [AREA_W-1:0] at2_q;
  // stage 3: intersection and area sum
  logic              v3_q;
  logic [IDX_W-1:0]  idx3_q;
  logic [REM_W-1:0]  inter3_q;
  logic [AREA_W:0]   sum3_q;
  // divider stages
  logic              dv_v_q   [DIV_STEPS+1];
  logic [IDX_W-1:0]  dv_idx_q [DIV_STEPS+1];
  logic [REM_W-1:0]  dv_r_q   [DIV_STEPS+1];
  logic [UNI_W-1:0]  dv_den_q [DIV_STEPS+1];
  logic [15:0]       dv_q_q   [DIV_STEPS+1];
  logic              dv_z_q   [DIV_STEPS+1];
  logic              dv_s_q   [DIV_STEPS+1];
  logic [REM_W-1:0]  step_r   [DIV_STEPS];
  logic              step_ge  [DIV_STEPS];

  logic signed [CRN_W-1:0] tl, tr, tt, tb, xa, xb, ya, yb;
  logic signed [CRN_W-1:0] ddx, ddy;
  logic [2*SPAN_W-1:0]     at_full;
  logic [UNI_W-1:0]        uni;
  logic [REM_W-1:0]        shl;

  always_comb begin
    tl = $signed({4'd0, cxw1_q, 1'b0}) - $signed({5'd0, ws1_q});
    tr = $signed({4'd0, cxw1_q, 1'b0}) + $signed({5'd0, ws1_q});
    tt = $signed({4'd0, cyh1_q, 1'b0}) - $signed({5'd0, hs1_q});
    tb = $signed({4'd0, cyh1_q, 1'b0}) + $signed({5'd0, hs1_q});
    xa = (pred_i.pl > tl) ? pred_i.pl : tl;
    xb = (pred_i.pr < tr) ? pred_i.pr : tr;
    ya = (pred_i.pt > tt) ? pred_i.pt : tt;
    yb = (pred_i.pb < tb) ? pred_i.pb : tb;
    ddx = xb - xa;
    ddy = yb - ya;
    at_full = ws1_q * hs1_q;
    uni = {sum3_q, 34'd0} - inter3_q[UNI_W-1:0];
  end

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      shl = {dv_r_q[k][REM_W-2:0], 1'b0};
      step_ge[k] = shl >= {1'b0, dv_den_q[k]};
      step_r[k]  = step_ge[k] ? shl - {1'b0, dv_den_q[k]} : shl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dv_v_q[k] <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      dv_v_q[0] <= v3_q;
      for (int k = 0; k < DIV_STEPS; k++) dv_v_q[k+1] <= dv_v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= idx_i;
    ws1_q  <= SPAN_W'(entry_i[47:32]) * SPAN_W'(img_w_i);
    hs1_q  <= SPAN_W'(entry_i[63:48]) * SPAN_W'(img_h_i);
    cxw1_q <= SPAN_W'(entry_i[15:0])  * SPAN_W'(img_w_i);
    cyh1_q <= SPAN_W'(entry_i[31:16]) * SPAN_W'(img_h_i);

    idx2_q <= idx1_q;
    dx2_q  <= (ddx > 0) ? OVL_W'(ddx) : '0;
    dy2_q  <= (ddy > 0) ? OVL_W'(ddy) : '0;
    at2_q  <= at_full[2*SPAN_W-1:32];

    idx3_q   <= idx2_q;
    inter3_q <= REM_W'(64'(dx2_q) * 64'(dy2_q));
    sum3_q   <= {1'b0, pred_i.area} + {1'b0, at2_q};

    dv_idx_q[0] <= idx3_q;
    dv_r_q[0]   <= inter3_q;
    dv_den_q[0] <= uni;
    dv_q_q[0]   <= '0;
    dv_z_q[0]   <= (uni == '0);
    dv_s_q[0]   <= (inter3_q >= {1'b0, uni});
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_idx_q[k+1] <= dv_idx_q[k];
      dv_r_q[k+1]   <= step_r[k];
      dv_den_q[k+1] <= dv_den_q[k];
      dv_q_q[k+1]   <= {dv_q_q[k][14:0], step_ge[k]};
      dv_z_q[k+1]   <= dv_z_q[k];
      dv_s_q[k+1]   <= dv_s_q[k];
    end
  end

  assign res_o.valid = dv_v_q[DIV_STEPS];
  assign res_o.idx   = dv_idx_q[DIV_STEPS];
  assign res_o.iou   = dv_z_q[DIV_STEPS] ? 16'd0 :
                       dv_s_q[DIV_STEPS] ? 16'hFFFF : dv_q_q[DIV_STEPS];

endmodule

/* src/iou_detection_matcher.sv */
// Top level of the greedy IoU detection matcher.
// Holds up to 64 ground-truth boxes in a single-port-read table memory.
// Clear, load and close words finish on the accept edge and then pass through the
// emit state before the next word can be taken. A score word streams every live
// entry through a pipelined scorer (spans, overlaps, intersection, union, then 16
// one-bit divide stages), one entry per cycle; a match then compacts the table by
// one read and one write per entry behind the winner. The memory read port sets
// the one-entry-per-cycle walk.
// One word is worked on at a time; a finished result waits in the output
// register while the next word is taken.
module iou_detection_matcher (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  idm_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output idm_pkg::out_word_t  out_word_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import idm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_DECIDE  = 5'b00100,
    ST_COMPACT = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [12:0] img_w_q, img_h_q;
  logic [15:0] thresh_q;

  // totals and table occupancy
  logic [CNT_W-1:0] live_q;
  logic [31:0]      tp_q, fp_q, fn_q;

  // table memory
  logic [63:0]      mem [MAX_BOXES];
  logic [63:0]      rdata_q;
  logic [IDX_W-1:0] raddr;
  logic             mem_we;
  logic [IDX_W-1:0] waddr;
  logic [63:0]      wdata;

  // scan bookkeeping
  pred_t            pred_q;
  logic [CNT_W-1:0] iss_q, ret_q;
  logic             rd_v_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [15:0]      best_q;
  logic [IDX_W-1:0] win_q;
  score_res_t       res;

  // compaction
  logic [CNT_W-1:0] cp_rd_q;
  logic             cp_wv_q;
  logic [IDX_W-1:0] cp_wa_q;

  // pending result fields
  logic             r_match_q, r_full_q;
  logic [15:0]      r_best_q;
  out_word_t        out_q;
  logic             out_v_q;

  logic accept, out_free, scan_issue, cp_issue, is_match;
  logic [32:0] tp_inc, fp_inc, fn_inc;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_v_q || !out_stall_i;
  assign scan_issue = (state_q == ST_SCAN) && (iss_q < live_q);
  assign cp_issue   = (state_q == ST_COMPACT) && (cp_rd_q <= live_q);
  assign is_match   = (best_q != 16'd0) && (best_q >= thresh_q);
  assign tp_inc     = {1'b0, tp_q} + 33'd1;
  assign fp_inc     = {1'b0, fp_q} + 33'd1;
  assign fn_inc     = {1'b0, fn_q} + 33'(live_q);

  // memory address and write selection
  always_comb begin
    raddr  = scan_issue ? iss_q[IDX_W-1:0] : cp_rd_q[IDX_W-1:0];
    mem_we = 1'b0;
    waddr  = cp_wa_q;
    wdata  = rdata_q;
    if (accept && in_word_i.opcode == OP_LOAD && live_q < CNT_W'(MAX_BOXES)) begin
      mem_we = 1'b1;
      waddr  = live_q[IDX_W-1:0];
      wdata  = {in_word_i.truth_box_h, in_word_i.truth_box_w,
                in_word_i.truth_center_y, in_word_i.truth_center_x};
    end else if (cp_wv_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  idm_score_pipe u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_v_q),
    .idx_i   (rd_idx_q),
    .entry_i (rdata_q),
    .pred_i  (pred_q),
    .img_w_i (img_w_q),
    .img_h_i (img_h_q),
    .res_o   (res)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = (in_word_i.opcode == OP_SCORE) ? ST_SCAN : ST_EMIT;
      end
      ST_SCAN: begin
        if (ret_q == live_q) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = is_match ? ST_COMPACT : ST_EMIT;
      end
      ST_COMPACT: begin
        if (!cp_issue && !cp_wv_q) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      img_w_q   <= 13'd640;
      img_h_q   <= 13'd640;
      thresh_q  <= 16'd32768;
      live_q    <= '0;
      tp_q      <= '0;
      fp_q      <= '0;
      fn_q      <= '0;
      iss_q     <= '0;
      ret_q     <= '0;
      rd_v_q    <= 1'b0;
      cp_wv_q   <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_IMAGE_WIDTH:  img_w_q  <= cfg_data_i[12:0];
          REG_IMAGE_HEIGHT: img_h_q  <= cfg_data_i[12:0];
          REG_MATCH_THRESH: thresh_q <= cfg_data_i;
          default: ;
        endcase
      end

      // clear, load and close finish on the accept edge; a score word resets the walk counters
      if (accept) begin
        unique case (in_word_i.opcode)
          OP_CLEAR: live_q <= '0;
          OP_LOAD:  if (live_q < CNT_W'(MAX_BOXES)) live_q <= live_q + 1'b1;
          OP_CLOSE: fn_q <= fn_inc[32] ? 32'hFFFF_FFFF : fn_inc[31:0];
          default: begin
            iss_q <= '0;
            ret_q <= '0;
          end
        endcase
      end

      // walk the table into the scorer
      rd_v_q <= scan_issue;
      if (scan_issue) iss_q <= iss_q + 1'b1;
      if (res.valid) ret_q <= ret_q + 1'b1;

      // count the outcome; on a match drop the winner and shift later entries down
      if (state_q == ST_DECIDE) begin
        if (is_match) begin
          tp_q   <= tp_inc[32] ? 32'hFFFF_FFFF : tp_inc[31:0];
          live_q <= live_q - 1'b1;
        end else begin
          fp_q <= fp_inc[32] ? 32'hFFFF_FFFF : fp_inc[31:0];
        end
      end
      cp_wv_q <= cp_issue;

      // hold the result until the output register frees up
      if (state_q == ST_EMIT && out_free) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= iss_q[IDX_W-1:0];
    if (accept) begin
      r_match_q <= 1'b0;
      r_best_q  <= '0;
      r_full_q  <= (in_word_i.opcode == OP_LOAD) && (live_q == CNT_W'(MAX_BOXES));
      best_q    <= '0;
      win_q     <= '0;
      pred_q.pl <= CRN_W'(in_word_i.pred_left) <<< FRAC_SHIFT;
      pred_q.pt <= CRN_W'(in_word_i.pred_top)  <<< FRAC_SHIFT;
      pred_q.pr <= (CRN_W'(in_word_i.pred_left) + CRN_W'(in_word_i.pred_w)) <<< FRAC_SHIFT;
      pred_q.pb <= (CRN_W'(in_word_i.pred_top)  + CRN_W'(in_word_i.pred_h)) <<< FRAC_SHIFT;
      pred_q.area <= AREA_W'(in_word_i.pred_w) * AREA_W'(in_word_i.pred_h);
    end
    // first strictly greater score wins
    if (res.valid && res.iou > best_q) begin
      best_q <= res.iou;
      win_q  <= res.idx;
    end
    if (state_q == ST_DECIDE) begin
      r_match_q <= is_match;
      r_best_q  <= best_q;
      cp_rd_q   <= {1'b0, win_q} + 1'b1;
    end
    if (cp_issue) begin
      cp_rd_q <= cp_rd_q + 1'b1;
      cp_wa_q <= IDX_W'(cp_rd_q - 1'b1);
    end
    if (state_q == ST_EMIT && out_free) begin
      out_q.matched         <= r_match_q;
      out_q.best_iou        <= r_best_q;
      out_q.true_pos_count  <= tp_q;
      out_q.false_pos_count <= fp_q;
      out_q.false_neg_count <= fn_q;
      out_q.boxes_left      <= live_q;
      out_q.table_full      <= r_full_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CNT_W'(MAX_BOXES))
    else $error("live count exceeds table depth");

  a_retire_le_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ret_q <= iss_q && iss_q <= live_q))
    else $error("scorer retired more entries than issued");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !mem_we)
    else $error("table written during scan");

  a_match_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.matched) |-> (out_q.best_iou != 16'd0))
    else $error("match reported with zero IoU");

endmodule
